FILE: rtl/core/scm_pkg.sv
`timescale 1ns / 1ps
package scm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_WORD0  = 3'd3;

    localparam logic [CHAR_W-1:0] TERMINATOR_RESET = 8'd13;
    localparam logic [CHAR_W-1:0] DELIMITER_RESET  = 8'd32;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

FILE: rtl/core/scm_front.sv
`timescale 1ns / 1ps
module scm_front #(
    parameter int BUFFER_SIZE   = 32,
    parameter int COMMAND_CHARS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scm_pkg::cfg_wr_t                    cfg,
    input  logic                                accept,
    input  logic [scm_pkg::CHAR_W-1:0]          in_char,
    output logic                                push,
    output logic [8*COMMAND_CHARS-1:0]          push_chars,
    output logic [$clog2(COMMAND_CHARS+1)-1:0]  push_len,
    output logic                                push_too_long
);

    localparam int CW    = 8 * COMMAND_CHARS;
    localparam int LEN_W = $clog2(COMMAND_CHARS + 1);
    localparam int LFW   = $clog2(BUFFER_SIZE);
    localparam logic [LFW-1:0]   FILL_LAST = LFW'(BUFFER_SIZE - 1);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(COMMAND_CHARS);

    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_INSIDE = 3'b010,
        PH_AFTER  = 3'b100
    } phase_t;

    logic [scm_pkg::CHAR_W-1:0] term_reg, delim_reg;
    logic [LFW-1:0]   fill_reg, fill_next;
    phase_t           phase_reg, phase_next;
    logic [CW-1:0]    chars_reg, chars_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             long_reg, long_next;

    logic [scm_pkg::CHAR_W-1:0] ch;
    logic printable, is_term, do_store;

    // upper-case, then classify
    always_comb
    begin
        ch = in_char;
        if (in_char >= 8'h61 && in_char <= 8'h7A)
        begin
            ch = in_char - 8'd32;
        end
        printable = (ch >= 8'h20) && (ch <= 8'h7E);
        is_term   = (ch == term_reg);
    end

    assign push          = accept && is_term && (phase_reg != PH_BEFORE);
    assign push_chars    = chars_reg;
    assign push_len      = len_reg;
    assign push_too_long = long_reg;

    always_comb
    begin
        fill_next  = fill_reg;
        phase_next = phase_reg;
        chars_next = chars_reg;
        len_next   = len_reg;
        long_next  = long_reg;
        do_store   = printable;
        if (is_term)
        begin
            // terminator clears the line; an empty line also drops the char
            do_store   = printable && (phase_reg != PH_BEFORE);
            fill_next  = '0;
            phase_next = PH_BEFORE;
            chars_next = '0;
            len_next   = '0;
            long_next  = 1'b0;
        end
        if (do_store)
        begin
            unique case (phase_next)
                PH_BEFORE:
                begin
                    if (ch != delim_reg)
                    begin
                        chars_next = CW'(ch);
                        len_next   = LEN_W'(1);
                        phase_next = PH_INSIDE;
                    end
                end
                PH_INSIDE:
                begin
                    if (ch == delim_reg)
                    begin
                        phase_next = PH_AFTER;
                    end
                    else if (len_next < LEN_MAX)
                    begin
                        for (int k = 0; k < COMMAND_CHARS; k++)
                        begin
                            if (LEN_W'(k) == len_next)
                            begin
                                chars_next[8*k +: 8] = ch;
                            end
                        end
                        len_next = len_next + 1'b1;
                    end
                    else
                    begin
                        long_next = 1'b1;
                    end
                end
                PH_AFTER:
                begin
                    phase_next = PH_AFTER;
                end
                default:
                begin
                    phase_next = PH_BEFORE;
                end
            endcase
            fill_next = fill_next + 1'b1;
            if (fill_next == FILL_LAST)
            begin
                fill_next  = '0;
                phase_next = PH_BEFORE;
                chars_next = '0;
                len_next   = '0;
                long_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg  <= scm_pkg::TERMINATOR_RESET;
            delim_reg <= scm_pkg::DELIMITER_RESET;
            fill_reg  <= '0;
            phase_reg <= PH_BEFORE;
            chars_reg <= '0;
            len_reg   <= '0;
            long_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.en && cfg.idx == scm_pkg::REG_TERMINATOR)
            begin
                term_reg <= cfg.data[scm_pkg::CHAR_W-1:0];
            end
            if (cfg.en && cfg.idx == scm_pkg::REG_DELIMITER)
            begin
                delim_reg <= cfg.data[scm_pkg::CHAR_W-1:0];
            end
            if (accept)
            begin
                fill_reg  <= fill_next;
                phase_reg <= phase_next;
                chars_reg <= chars_next;
                len_reg   <= len_next;
                long_reg  <= long_next;
            end
        end
    end

endmodule

FILE: rtl/core/scm_queue.sv
`timescale 1ns / 1ps
module scm_queue #(
    parameter int WIDTH = 69
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/scm_back.sv
`timescale 1ns / 1ps
module scm_back #(
    parameter int NUM_COMMANDS  = 4,
    parameter int COMMAND_CHARS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scm_pkg::cfg_wr_t                    cfg,
    input  logic                                q_valid,
    input  logic [8*COMMAND_CHARS-1:0]          q_chars,
    input  logic [$clog2(COMMAND_CHARS+1)-1:0]  q_len,
    input  logic                                q_too_long,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                match_found,
    output logic [scm_pkg::INDEX_W-1:0]         command_index
);

    localparam int CW    = 8 * COMMAND_CHARS;
    localparam int LEN_W = $clog2(COMMAND_CHARS + 1);
    localparam logic [2:0] NUM_CMD = 3'(NUM_COMMANDS);

    logic [CW-1:0] word_reg [NUM_COMMANDS];
    logic [2:0]    count_reg;
    logic [2:0]    eff_count;

    logic          out_valid_reg, match_reg;
    logic [scm_pkg::INDEX_W-1:0] index_reg;

    logic [NUM_COMMANDS-1:0] cmd_eq;
    logic                    hit;
    logic [scm_pkg::INDEX_W-1:0] hit_idx;

    assign eff_count = (count_reg > NUM_CMD) ? NUM_CMD : count_reg;

    // per command: word not too long, bytes below the word length equal, byte at
    // the length is the zero pad (unless the word fills all slots)
    always_comb
    begin
        for (int i = 0; i < NUM_COMMANDS; i++)
        begin
            cmd_eq[i] = !q_too_long;
            for (int k = 0; k < COMMAND_CHARS; k++)
            begin
                if (LEN_W'(k) < q_len)
                begin
                    cmd_eq[i] = cmd_eq[i] && (word_reg[i][8*k +: 8] == q_chars[8*k +: 8]);
                end
                else if (LEN_W'(k) == q_len)
                begin
                    cmd_eq[i] = cmd_eq[i] && (word_reg[i][8*k +: 8] == 8'h00);
                end
            end
        end
    end

    // first installed command that matches wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < NUM_COMMANDS; i++)
        begin
            if (!hit && (3'(i) < eff_count) && cmd_eq[i])
            begin
                hit     = 1'b1;
                hit_idx = scm_pkg::INDEX_W'(i);
            end
        end
    end

    assign q_pop         = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid     = out_valid_reg;
    assign match_found   = match_reg;
    assign command_index = index_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            match_reg <= hit;
            index_reg <= hit_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < NUM_COMMANDS; i++)
            begin
                word_reg[i] <= '0;
            end
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.en && cfg.idx == scm_pkg::REG_CMD_COUNT)
            begin
                count_reg <= cfg.data[2:0];
            end
            for (int i = 0; i < NUM_COMMANDS; i++)
            begin
                if (cfg.en && cfg.idx == scm_pkg::REG_CMD_WORD0 + scm_pkg::CFG_IDX_W'(i))
                begin
                    word_reg[i] <= cfg.data[CW-1:0];
                end
            end
        end
    end

endmodule

FILE: rtl/core/serial_command_matcher_top.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+-----------------------------------
// input    | in  | in_valid / in_stall  | in_char[7:0]
// result   | out | out_valid/ out_stall | match_found, command_index[1:0]
// config   | in  | cfg_wr_en            | cfg_index[2:0], cfg_data[63:0]
//
// One character beat per cycle while in_stall is low; a terminator beat on
// a line with a word yields a result beat: the word goes into the queue, the
// back pops it, compares it and loads the output register (held by out_stall).
// Reset is asynchronous, active low; no clearing pass, ready right away.
// A two-entry queue sits between front and back; in_stall rises only when
// it is full, i.e. when results back up behind a stalled output.
module serial_command_matcher_top #(
    parameter int BUFFER_SIZE   = 32,
    parameter int NUM_COMMANDS  = 4,
    parameter int COMMAND_CHARS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // character input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [scm_pkg::CHAR_W-1:0]         in_char,
    // result output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               match_found,
    output logic [scm_pkg::INDEX_W-1:0]        command_index,
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [scm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW    = 8 * COMMAND_CHARS;
    localparam int LEN_W = $clog2(COMMAND_CHARS + 1);
    localparam int QW    = 1 + LEN_W + CW;

    scm_pkg::cfg_wr_t cfg;

    logic             accept;
    logic             push, q_full, q_valid, q_pop;
    logic [CW-1:0]    push_chars, q_chars;
    logic [LEN_W-1:0] push_len, q_len;
    logic             push_too_long, q_too_long;
    logic [QW-1:0]    q_data;

    assign cfg.en   = cfg_wr_en;
    assign cfg.idx  = cfg_index;
    assign cfg.data = cfg_data;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // front: case fold, classify, track the first word of the line
    scm_front #(
        .BUFFER_SIZE   (BUFFER_SIZE),
        .COMMAND_CHARS (COMMAND_CHARS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .accept        (accept),
        .in_char       (in_char),
        .push          (push),
        .push_chars    (push_chars),
        .push_len      (push_len),
        .push_too_long (push_too_long)
    );

    // word snapshots waiting for the compare stage
    scm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_too_long, push_len, push_chars}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    assign q_too_long = q_data[QW-1];
    assign q_len      = q_data[CW +: LEN_W];
    assign q_chars    = q_data[CW-1:0];

    // back: parallel compare against installed commands, output register
    scm_back #(
        .NUM_COMMANDS  (NUM_COMMANDS),
        .COMMAND_CHARS (COMMAND_CHARS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_chars       (q_chars),
        .q_len         (q_len),
        .q_too_long    (q_too_long),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_found   (match_found),
        .command_index (command_index)
    );

endmodule
